### design/dtsc_pkg.sv
// ----------------------------------------------------------------------------
// dtsc_pkg
// Shared constants, phase codes, ascii codes and control structs for the
// decimal token sum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsc_pkg;

  // sum width, value range is 0 .. 2^(SUM_BITS-1)-1
  localparam int SUM_BITS   = 64;
  localparam int VAL_W      = SUM_BITS - 1;
  // digit cells of the reply, enough for the largest total
  localparam int NUM_DIGITS = 19;
  localparam int CNT_MAX    = (VAL_W > NUM_DIGITS) ? VAL_W : NUM_DIGITS;
  localparam int CNT_W      = $clog2(CNT_MAX);
  localparam int ERR_LEN    = 5;
  localparam int ERR_IDX_W  = $clog2(ERR_LEN);

  // token phase codes
  localparam logic [2:0] PH_BETWEEN = 3'd0;
  localparam logic [2:0] PH_LEADWS  = 3'd1;
  localparam logic [2:0] PH_SIGN    = 3'd2;
  localparam logic [2:0] PH_DIGITS  = 3'd3;

  // ascii codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_O     = 8'h4F;

  // commands to the token parser
  typedef struct packed {
    logic       take;
    logic [7:0] data_byte;
    logic       close;
    logic       shift;
    logic       restart;
  } dtsc_parse_ctl_t;

  // parser status
  typedef struct packed {
    logic err;
    logic total_msb;
    logic total_zero;
  } dtsc_parse_sts_t;

  // commands to the digit cell row
  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } dtsc_cell_ctl_t;

  // characters of the error reply
  function automatic logic [7:0] err_char(input logic [ERR_IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      ERR_IDX_W'(0): c = CH_E;
      ERR_IDX_W'(1): c = CH_R;
      ERR_IDX_W'(2): c = CH_R;
      ERR_IDX_W'(3): c = CH_O;
      ERR_IDX_W'(4): c = CH_R;
      default:       c = CH_E;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### design/dtsc_in_if.sv
// ----------------------------------------------------------------------------
// dtsc_in_if
// Input channel: at most one datagram byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsc_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output has_byte, output data_byte,
                  output end_of_datagram, input ready);
  modport sink   (input valid, input has_byte, input data_byte,
                  input end_of_datagram, output ready);
endinterface

`default_nettype wire

### design/dtsc_out_if.sv
// ----------------------------------------------------------------------------
// dtsc_out_if
// Output channel: one reply character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_char;
  logic       reply_is_error;
  logic       reply_last;

  modport source (output valid, output reply_char, output reply_is_error,
                  output reply_last, input ready);
  modport sink   (input valid, input reply_char, input reply_is_error,
                  input reply_last, output ready);
endinterface

`default_nettype wire

### design/dtsc_parser.sv
// ----------------------------------------------------------------------------
// dtsc_parser
// Token parser: accumulates the token value, checks syntax and range,
// adds finished tokens into the running total and shifts the total out.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsc_parser
  import dtsc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dtsc_parse_ctl_t ctl_i,
  output dtsc_parse_sts_t      sts_o
);

  logic [VAL_W-1:0] total_q, total_d;
  logic [VAL_W-1:0] tok_q, tok_d;
  logic [2:0]       phase_q, phase_d;
  logic             pzero_q, pzero_d;
  logic             err_q, err_d;

  logic [VAL_W+3:0] prod;
  logic [VAL_W:0]   sum;
  logic [3:0]       digit;
  logic             is_digit;
  logic             is_ws;
  logic             lead_ok;
  logic             mul_ovf;
  logic             close_err;
  logic             do_close;

  // byte classes
  assign is_digit = (ctl_i.data_byte >= CH_ZERO) && (ctl_i.data_byte <= CH_NINE);
  assign is_ws    = (ctl_i.data_byte >= CH_TAB) && (ctl_i.data_byte <= CH_CR);
  assign lead_ok  = (phase_q == PH_BETWEEN) || (phase_q == PH_LEADWS);
  assign digit    = ctl_i.data_byte[3:0];

  // value * 10 + digit, overflow when anything lands above the value range
  assign prod    = ({4'b0, tok_q} << 3) + ({4'b0, tok_q} << 1) + (VAL_W + 4)'(digit);
  assign mul_ovf = |prod[VAL_W+3:VAL_W];

  // token close checks
  assign sum       = {1'b0, total_q} + {1'b0, tok_q};
  assign close_err = (phase_q != PH_DIGITS) || ((tok_q == '0) && !pzero_q) || sum[VAL_W];
  assign do_close  = ctl_i.close || (ctl_i.take && !err_q && (ctl_i.data_byte == CH_SPACE));

  // next state
  always_comb begin
    total_d = total_q;
    tok_d   = tok_q;
    phase_d = phase_q;
    pzero_d = pzero_q;
    err_d   = err_q;
    if (ctl_i.restart) begin
      total_d = '0;
      err_d   = 1'b0;
    end else if (ctl_i.shift) begin
      total_d = {total_q[VAL_W-2:0], 1'b0};
    end else if (do_close) begin
      if ((phase_q != PH_BETWEEN) && !err_q) begin
        if (close_err) begin
          err_d = 1'b1;
        end else begin
          total_d = sum[VAL_W-1:0];
        end
      end
      phase_d = PH_BETWEEN;
      tok_d   = '0;
      pzero_d = 1'b0;
    end else if (ctl_i.take && !err_q) begin
      if (is_digit) begin
        pzero_d = (phase_q == PH_BETWEEN) && (digit == 4'd0);
        if (mul_ovf) begin
          err_d = 1'b1;
        end else begin
          tok_d   = prod[VAL_W-1:0];
          phase_d = PH_DIGITS;
        end
      end else begin
        pzero_d = 1'b0;
        if (is_ws && lead_ok) begin
          phase_d = PH_LEADWS;
        end else if ((ctl_i.data_byte == CH_PLUS) && lead_ok) begin
          phase_d = PH_SIGN;
        end else begin
          err_d = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      tok_q   <= '0;
      phase_q <= PH_BETWEEN;
      pzero_q <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      total_q <= total_d;
      tok_q   <= tok_d;
      phase_q <= phase_d;
      pzero_q <= pzero_d;
      err_q   <= err_d;
    end
  end

  assign sts_o.err        = err_q;
  assign sts_o.total_msb  = total_q[VAL_W-1];
  assign sts_o.total_zero = (total_q == '0);

endmodule

`default_nettype wire

### design/dtsc_bcd_cell.sv
// ----------------------------------------------------------------------------
// dtsc_bcd_cell
// One decimal digit cell: shift-and-add-3 step during conversion, plain
// digit shift toward the top during reply output.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsc_bcd_cell
  import dtsc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire dtsc_cell_ctl_t ctl_i,
  input  wire logic           bit_i,
  input  wire logic [3:0]     digit_i,
  output logic                bit_o,
  output logic [3:0]          digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // add 3 when the digit would pass 9 after doubling
  assign adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctl_i.conv) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctl_i.shift) begin
      digit_d = digit_i;
    end
  end

  // digit storage, no reset needed
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

endmodule

`default_nettype wire

### design/dtsc_digit_chain.sv
// ----------------------------------------------------------------------------
// dtsc_digit_chain
// Row of decimal digit cells; binary bits enter at the bottom cell, reply
// digits leave at the top cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsc_digit_chain
  import dtsc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire dtsc_cell_ctl_t ctl_i,
  input  wire logic           bit_i,
  output logic [3:0]          top_digit_o
);

  logic [NUM_DIGITS:0] carry;
  logic [3:0]          digits [NUM_DIGITS+1];

  assign carry[0]  = bit_i;
  assign digits[0] = 4'd0;

  // cell i takes from cell i-1
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    dtsc_bcd_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .bit_i   (carry[i]),
      .digit_i (digits[i]),
      .bit_o   (carry[i+1]),
      .digit_o (digits[i+1])
    );
  end

  assign top_digit_o = digits[NUM_DIGITS];

endmodule

`default_nettype wire

### design/decimal_token_sum_checker_unit.sv
// ----------------------------------------------------------------------------
// decimal_token_sum_checker_unit
// Sums the decimal tokens of a datagram and replies with the total in
// ascii decimal or the text ERROR.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle within a datagram.
// Final item: the last token is closed and checked, then an ERROR reply
//   is sent from S_ERR, or the total is shifted into the digit cell row
//   and sent from its NUM_DIGITS (19) cells, waiting while output stalls.
// Input is not taken while a reply is built; the last reply byte may wait
//   in the output register while the next datagram starts.
// Reset: asynchronous, active low; total, token and error state cleared.
`default_nettype none

module decimal_token_sum_checker_unit
  import dtsc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dtsc_in_if.sink     in_i,
  dtsc_out_if.source  out_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLOSE  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_CONV   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_ERR    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             started_q, started_d;

  logic             ovalid_q, ovalid_d;
  logic [7:0]       ochar_q, ochar_d;
  logic             oerr_q, oerr_d;
  logic             olast_q, olast_d;

  dtsc_parse_ctl_t  pctl;
  dtsc_parse_sts_t  psts;
  dtsc_cell_ctl_t   cctl;
  logic [3:0]       top_digit;
  logic             in_xfer;
  logic             out_free;
  logic             last_dig;
  logic             emit_now;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;
  assign last_dig   = (cnt_q == CNT_W'(NUM_DIGITS - 1));
  assign emit_now   = started_q || (top_digit != 4'd0) || last_dig;

  // token parser
  dtsc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pctl),
    .sts_o  (psts)
  );

  // decimal digit cell row
  dtsc_digit_chain u_chain (
    .clk_i       (clk_i),
    .ctl_i       (cctl),
    .bit_i       (psts.total_msb),
    .top_digit_o (top_digit)
  );

  // sequencer
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    started_d      = started_q;
    ovalid_d       = ovalid_q && !out_o.ready;
    ochar_d        = ochar_q;
    oerr_d         = oerr_q;
    olast_d        = olast_q;
    pctl.take      = 1'b0;
    pctl.data_byte = in_i.data_byte;
    pctl.close     = 1'b0;
    pctl.shift     = 1'b0;
    pctl.restart   = 1'b0;
    cctl.clear     = 1'b0;
    cctl.conv      = 1'b0;
    cctl.shift     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          pctl.take = in_i.has_byte;
          if (in_i.end_of_datagram) begin
            state_d = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        pctl.close = 1'b1;
        cctl.clear = 1'b1;
        cnt_d      = '0;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (psts.err) begin
          pctl.restart = 1'b1;
          state_d      = S_ERR;
        end else begin
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        pctl.shift = 1'b1;
        cctl.conv  = 1'b1;
        if (cnt_q == CNT_W'(VAL_W - 1)) begin
          cnt_d     = '0;
          started_d = 1'b0;
          state_d   = S_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (!emit_now || out_free) begin
          cctl.shift = 1'b1;
          started_d  = started_q || emit_now;
          cnt_d      = cnt_q + 1'b1;
          if (emit_now) begin
            ovalid_d = 1'b1;
            ochar_d  = CH_ZERO + {4'd0, top_digit};
            oerr_d   = 1'b0;
            olast_d  = last_dig;
          end
          if (last_dig) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ochar_d  = err_char(cnt_q[ERR_IDX_W-1:0]);
          oerr_d   = 1'b1;
          olast_d  = (cnt_q == CNT_W'(ERR_LEN - 1));
          cnt_d    = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ERR_LEN - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
    oerr_q  <= oerr_d;
    olast_q <= olast_d;
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.reply_char     = ochar_q;
  assign out_o.reply_is_error = oerr_q;
  assign out_o.reply_last     = olast_q;

  // a final item starts the token close
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.end_of_datagram |=> state_q == S_CLOSE)
    else $error("final item did not start token close");

  // the total has been fully shifted into the digit row before output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && $past(state_q == S_CONV) |-> psts.total_zero)
    else $error("total not drained at start of reply");

  // numeric reply bytes are decimal digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !oerr_q |-> (ochar_q >= CH_ZERO) && (ochar_q <= CH_NINE))
    else $error("numeric reply byte is not a digit");

  // error reply ends on its final R
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oerr_q && olast_q |-> ochar_q == CH_R)
    else $error("error reply ends on a wrong byte");

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for decimal_token_sum_checker_unit. A short table of
// hand-made datagrams (empty, plain zero, sign and whitespace rules, error
// bytes) is followed by random datagrams, mostly well-formed token lists
// with random values and some noise and broken ones. A built-in datagram
// summer predicts each reply the table does not give, and a monitor compares each
// output transfer against the oldest pending character. Both channels idle
// at random, and the reply side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import dtsc_pkg::*;
();

  localparam int             NUM_ITEMS  = 320;
  localparam int             LONG_HOLD  = 400;
  localparam int             DRAIN_CYC  = 200;
  localparam int             WAIT_LIMIT = 200000;
  localparam logic [7:0]     CH_MINUS   = 8'h2D;
  localparam logic [63:0]    MAX_VALUE  = (64'd1 << VAL_W) - 64'd1;

  typedef struct packed {
    logic       has;
    logic [7:0] b;
    logic       eod;
  } dgram_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_err;
    logic       last;
  } reply_char_t;

  logic clk_i;
  logic rst_ni;

  dtsc_in_if  in_if ();
  dtsc_out_if out_if ();

  decimal_token_sum_checker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock and reset
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // datagram summer state
  logic [63:0] sum_tot;
  logic [63:0] tok_val;
  logic [2:0]  tok_phase;
  bit          tok_zero;
  bit          sum_err;

  reply_char_t reply_q[$];
  dgram_item_t dir_items[$];
  string       dir_want[$];
  logic [7:0]  dgram[$];

  int mismatches;
  int chars_seen;
  int n_replies;
  int n_err_replies;
  int items_sent;
  bit long_hold_done;

  // close the current token and add it to the total
  function automatic void seal_token();
    if (tok_phase == PH_BETWEEN) return;
    if (!sum_err) begin
      if (tok_phase != PH_DIGITS) sum_err = 1'b1;
      else if (tok_val == 64'd0 && !tok_zero) sum_err = 1'b1;
      else if (tok_val > MAX_VALUE - sum_tot) sum_err = 1'b1;
      else sum_tot = sum_tot + tok_val;
    end
    tok_phase = PH_BETWEEN;
    tok_val   = 64'd0;
    tok_zero  = 1'b0;
  endfunction

  // one datagram byte into the token parser
  function automatic void absorb_byte(logic [7:0] b);
    logic [63:0] d;
    if (sum_err) return;
    if (b == CH_SPACE) begin
      seal_token();
      return;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = 64'(b - CH_ZERO);
      tok_zero = (tok_phase == PH_BETWEEN && d == 64'd0);
      if (tok_val > (MAX_VALUE - d) / 64'd10) begin
        sum_err = 1'b1;
        return;
      end
      tok_val   = tok_val * 64'd10 + d;
      tok_phase = PH_DIGITS;
      return;
    end
    tok_zero = 1'b0;
    if (b >= CH_TAB && b <= CH_CR &&
        (tok_phase == PH_BETWEEN || tok_phase == PH_LEADWS)) begin
      tok_phase = PH_LEADWS;
      return;
    end
    if (b == CH_PLUS && (tok_phase == PH_BETWEEN || tok_phase == PH_LEADWS)) begin
      tok_phase = PH_SIGN;
      return;
    end
    sum_err = 1'b1;
  endfunction

  // returns 1 with the reply text when the item closes a datagram
  function automatic bit tally_item(input dgram_item_t it, output string txt);
    txt = "";
    if (it.has) absorb_byte(it.b);
    if (!it.eod) return 1'b0;
    seal_token();
    if (sum_err) begin
      txt = "ERROR";
      n_err_replies++;
    end else begin
      txt = $sformatf("%0d", sum_tot);
    end
    n_replies++;
    sum_tot   = 64'd0;
    sum_err   = 1'b0;
    tok_val   = 64'd0;
    tok_phase = PH_BETWEEN;
    tok_zero  = 1'b0;
    return 1'b1;
  endfunction

  function automatic void queue_reply(string s);
    reply_char_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.ch     = s[i];
      r.is_err = (s == "ERROR");
      r.last   = (i == s.len() - 1);
      reply_q.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // idle length: mostly short, a few long
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_SPACE;
      2:       return CH_PLUS;
      3:       return CH_MINUS;
      4:       return 8'h00;
      5:       return CH_TAB + 8'($urandom_range(0, 4));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // append one token: optional whitespace, sign and leading zero, then digits
  function automatic void add_token();
    logic [63:0] v;
    string       s;
    int          k;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2)) dgram.push_back(CH_TAB + 8'($urandom_range(0, 4)));
    end
    if ($urandom_range(0, 6) == 0) dgram.push_back(CH_PLUS);
    if ($urandom_range(0, 19) == 0) dgram.push_back(CH_ZERO);
    if (k < 10) v = 64'd0;
    else if (k < 55) v = 64'($urandom_range(1, 999));
    else if (k < 70) v = {$urandom, $urandom} >> $urandom_range(1, 60);
    else if (k < 85) v = MAX_VALUE - 64'($urandom_range(0, 1000));
    else if (k < 90) v = (64'd1 << (VAL_W - 1)) + 64'($urandom_range(0, 100000));
    else v = MAX_VALUE + 64'd1 + 64'($urandom_range(0, 1000));
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) dgram.push_back(s[i]);
    // now and then push a too-large value past 64 bits
    if (k >= 90 && $urandom_range(0, 1) == 1)
      repeat ($urandom_range(1, 2)) dgram.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // build the bytes of one random datagram
  function automatic void make_datagram();
    int k;
    int ntok;
    dgram.delete();
    k = $urandom_range(0, 99);
    if (k < 6) return;
    if (k < 22) begin
      repeat ($urandom_range(1, 6)) dgram.push_back(noise_byte());
      return;
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) dgram.push_back(CH_SPACE);
    ntok = $urandom_range(1, 3);
    for (int t = 0; t < ntok; t++) begin
      add_token();
      if (t < ntok - 1) repeat ($urandom_range(1, 3)) dgram.push_back(CH_SPACE);
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) dgram.push_back(CH_SPACE);
    // broken sequence: one byte replaced
    if ($urandom_range(0, 99) < 15)
      dgram[$urandom_range(0, dgram.size() - 1)] = noise_byte();
  endfunction

  function automatic void row(bit has, logic [7:0] b, bit eod, string want);
    dgram_item_t it;
    it.has = has;
    it.b   = b;
    it.eod = eod;
    dir_items.push_back(it);
    dir_want.push_back(want);
  endfunction

  // one input transfer, then its predicted reply
  task automatic deliver(dgram_item_t it, int gap, string want);
    string txt;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.has_byte        <= it.has;
    in_if.data_byte       <= it.b;
    in_if.end_of_datagram <= it.eod;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (it.has || it.eod) items_sent++;
    if (tally_item(it, txt)) queue_reply((want.len() != 0) ? want : txt);
  endtask

  // stimulus and end of run
  initial begin
    dgram_item_t it;
    bit          calm;
    bit          close_apart;
    int          waited;
    in_if.valid           <= 1'b0;
    in_if.has_byte        <= 1'b0;
    in_if.data_byte       <= 8'h00;
    in_if.end_of_datagram <= 1'b0;
    sum_tot   = 64'd0;
    tok_val   = 64'd0;
    tok_phase = PH_BETWEEN;
    tok_zero  = 1'b0;
    sum_err   = 1'b0;

    // directed table
    row(1'b0, 8'h00,            1'b1, "0");      // empty datagram
    row(1'b0, 8'hFF,            1'b0, "");       // no byte, not final
    row(1'b1, CH_ZERO,          1'b1, "0");      // exactly zero
    row(1'b1, CH_ZERO + 8'd7,   1'b1, "7");
    row(1'b1, CH_MINUS,         1'b1, "ERROR");  // minus sign
    row(1'b1, 8'h00,            1'b1, "ERROR");  // zero byte
    row(1'b1, 8'hFF,            1'b1, "ERROR");  // other byte
    row(1'b1, CH_PLUS,          1'b1, "ERROR");  // token without digits
    row(1'b1, CH_TAB,           1'b0, "");       // whitespace, sign, two tokens
    row(1'b1, CH_PLUS,          1'b0, "");
    row(1'b1, CH_ZERO + 8'd5,   1'b0, "");
    row(1'b1, CH_SPACE,         1'b0, "");
    row(1'b1, CH_ZERO + 8'd1,   1'b0, "");
    row(1'b1, CH_ZERO + 8'd2,   1'b1, "");
    row(1'b1, CH_ZERO,          1'b0, "");       // double zero
    row(1'b1, CH_ZERO,          1'b1, "ERROR");
    row(1'b1, CH_PLUS,          1'b0, "");       // signed zero
    row(1'b1, CH_ZERO,          1'b1, "ERROR");
    row(1'b1, CH_ZERO + 8'd3,   1'b0, "");       // whitespace after a digit
    row(1'b1, CH_CR,            1'b1, "ERROR");
    row(1'b1, CH_MINUS,         1'b0, "");       // error sticks
    row(1'b1, CH_ZERO + 8'd4,   1'b1, "ERROR");
    row(1'b1, CH_SPACE,         1'b0, "");       // space runs, close without byte
    row(1'b1, CH_SPACE,         1'b0, "");
    row(1'b1, CH_ZERO + 8'd9,   1'b0, "");
    row(1'b1, CH_SPACE,         1'b0, "");
    row(1'b0, 8'h00,            1'b1, "9");

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    foreach (dir_items[i]) deliver(dir_items[i], idle_len(1'b0), dir_want[i]);

    // random datagrams
    while (items_sent < NUM_ITEMS) begin
      make_datagram();
      calm        = ($urandom_range(0, 3) == 0);
      close_apart = (dgram.size() == 0) || ($urandom_range(0, 9) < 3);
      foreach (dgram[i]) begin
        if ($urandom_range(0, 19) == 0) begin
          it.has = 1'b0;
          it.b   = 8'($urandom_range(0, 255));
          it.eod = 1'b0;
          deliver(it, idle_len(calm), "");
        end
        it.has = 1'b1;
        it.b   = dgram[i];
        it.eod = !close_apart && (i == dgram.size() - 1);
        deliver(it, idle_len(calm), "");
      end
      if (close_apart) begin
        it.has = 1'b0;
        it.b   = 8'($urandom_range(0, 255));
        it.eod = 1'b1;
        deliver(it, idle_len(calm), "");
      end
    end
    in_if.valid <= 1'b0;

    // drain
    waited = 0;
    while (reply_q.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYC) @(posedge clk_i);
    while (reply_q.size() != 0) begin
      note_mismatch($sformatf("reply char %h never arrived", reply_q[0].ch));
      void'(reply_q.pop_front());
    end

    $display("%0d input transfers, %0d replies (%0d ERROR), %0d reply chars checked",
             items_sent, n_replies, n_err_replies, chars_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("decimal_token_sum_checker_unit test passed");
    end else begin
      $display("decimal_token_sum_checker_unit test failed");
    end
    $finish;
  end

  // reply side: random ready, calm stretches, one long hold-off
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold_done && chars_seen >= 60) begin
        long_hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if ($urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk_i);
      end else begin
        n = idle_len(1'b0);
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // compare each reply transfer with the oldest pending char
  always @(posedge clk_i) begin : reply_check
    reply_char_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      chars_seen++;
      if (reply_q.size() == 0) begin
        note_mismatch($sformatf("unexpected reply char %h err %b last %b",
                                out_if.reply_char, out_if.reply_is_error,
                                out_if.reply_last));
      end else begin
        want = reply_q.pop_front();
        if (out_if.reply_char !== want.ch)
          note_mismatch($sformatf("reply_char exp %h got %h", want.ch, out_if.reply_char));
        if (out_if.reply_is_error !== want.is_err)
          note_mismatch($sformatf("reply_is_error exp %b got %b", want.is_err,
                                  out_if.reply_is_error));
        if (out_if.reply_last !== want.last)
          note_mismatch($sformatf("reply_last exp %b got %b on char %h", want.last,
                                  out_if.reply_last, want.ch));
      end
    end
  end

  // run limit
  initial begin
    #8000000;
    $display("timeout with %0d reply chars pending", reply_q.size());
    $display("decimal_token_sum_checker_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
